/* sv/cq_pkg.sv */
package cq_pkg;

   localparam int WORD_W   = 32;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_ENQUEUE = 2'd0,
      MODE_DEQUEUE = 2'd1,
      MODE_PEEK    = 2'd2,
      MODE_NOP     = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2,
      STATUS_RSVD      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FETCH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;  // capture the request transaction
      logic exec;      // update indices, write or read the store
      logic finish;    // present the response next cycle
      logic fetch;     // response data comes from the store
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic needs_read;
   } stat_type;

endpackage

/* sv/cq_ram.sv */
module cq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

endmodule

/* sv/cq_ctrl.sv */
module cq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  cq_pkg::stat_type stat,
   output cq_pkg::cmd_type  cmd,
   output logic             busy,
   output logic             csr_ready
);

   import cq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = stat.needs_read ? ST_FETCH : ST_IDLE;
         end
         ST_FETCH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      csr_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy         = 1'b0;
            csr_ready    = 1'b1;
            cmd.load_req = start;
         end
         ST_EXEC: begin
            cmd.exec   = 1'b1;
            cmd.finish = !stat.needs_read;
         end
         ST_FETCH: begin
            cmd.finish = 1'b1;
            cmd.fetch  = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

/* sv/cq_dpath.sv */
module cq_dpath #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cq_pkg::cmd_type                   cmd,
   output cq_pkg::stat_type                  stat,
   input  logic [cq_pkg::MODE_W-1:0]         req_mode,
   input  logic signed [cq_pkg::WORD_W-1:0]  req_value,
   input  logic                              csr_write,
   input  logic [cq_pkg::CSR_W-1:0]          csr_capacity_in_use,
   output logic                              rsp_valid,
   output logic signed [cq_pkg::WORD_W-1:0]  rsp_data,
   output logic [cq_pkg::STATUS_W-1:0]       rsp_status,
   output logic                              rsp_full_flag,
   output logic                              rsp_empty_flag
);

   import cq_pkg::*;

   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CAP_W     = $clog2(DEPTH + 1);
   localparam int CMP_W     = (CAP_W > CSR_W) ? CAP_W : CSR_W;
   localparam int CAP_RESET = (16 > DEPTH) ? DEPTH : 16;

   function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx,
                                                   input logic [CAP_W-1:0] cap);
      logic [CAP_W-1:0] n;
      n = CAP_W'(idx) + CAP_W'(1);
      return (n >= cap) ? '0 : IDX_W'(n);
   endfunction

   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   mode_type          mode_ff;
   logic [WORD_W-1:0] value_ff;
   logic              valid_ff;
   logic [WORD_W-1:0] data_ff, data_in;
   status_type        status_ff, status_in;
   logic              full_ff, full_in;
   logic              empty_ff, empty_in;

   logic [CMP_W-1:0]  cap_req;
   logic [IDX_W-1:0]  head_next;
   logic [IDX_W-1:0]  tail_next;
   logic              is_empty;
   logic              is_full;
   logic              ram_we;
   logic [WORD_W-1:0] ram_rdata;

   assign head_next = next_index(head_ff, cap_ff);
   assign tail_next = next_index(tail_ff, cap_ff);
   assign is_empty  = (head_ff == tail_ff);
   assign is_full   = (tail_next == head_ff);

   assign stat.needs_read = ((mode_ff == MODE_DEQUEUE) || (mode_ff == MODE_PEEK)) && !is_empty;

   // clamp the written capacity into 2..DEPTH
   always_comb begin
      cap_req = CMP_W'(csr_capacity_in_use);
      priority if (cap_req < CMP_W'(2)) begin
         cap_in = CAP_W'(2);
      end else if (cap_req > CMP_W'(DEPTH)) begin
         cap_in = CAP_W'(DEPTH);
      end else begin
         cap_in = CAP_W'(cap_req);
      end
   end

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      status_in = STATUS_OK;
      ram_we    = 1'b0;
      unique case (mode_ff)
         MODE_ENQUEUE: begin
            if (is_full) begin
               status_in = STATUS_OVERFLOW;
            end else begin
               tail_in = tail_next;
               ram_we  = cmd.exec;
            end
         end
         MODE_DEQUEUE: begin
            if (is_empty) begin
               status_in = STATUS_UNDERFLOW;
               head_in   = '0;
               tail_in   = '0;
            end else begin
               head_in = head_next;
            end
         end
         MODE_PEEK: begin
            if (is_empty) begin
               status_in = STATUS_UNDERFLOW;
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
      empty_in = (head_in == tail_in);
      full_in  = (next_index(tail_in, cap_ff) == head_in);
      data_in  = cmd.fetch ? ram_rdata : '0;
   end

   cq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (tail_next),
      .wdata    (value_ff),
      .re       (cmd.exec),
      .raddr    (head_next),
      .rdata_ff (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_W'(CAP_RESET);
         head_ff  <= '0;
         tail_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.finish;
         if (csr_write) begin
            // a capacity change empties the queue
            cap_ff  <= cap_in;
            head_ff <= '0;
            tail_ff <= '0;
         end else if (cmd.exec) begin
            head_ff <= head_in;
            tail_ff <= tail_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff  <= mode_type'(req_mode);
         value_ff <= req_value;
      end
      if (cmd.exec) begin
         status_ff <= status_in;
         full_ff   <= full_in;
         empty_ff  <= empty_in;
      end
      if (cmd.finish) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_data       = data_ff;
   assign rsp_status     = status_ff;
   assign rsp_full_flag  = full_ff;
   assign rsp_empty_flag = empty_ff;

endmodule

/* sv/circular_queue_one_slot_open_top.sv */
// Ring-buffer FIFO of 32-bit words that keeps one slot open, so at most
// capacity_in_use - 1 words are held. A request transaction (enqueue,
// dequeue or peek) is taken when start is high and busy is low. Enqueue and
// any underflow or no-op request go through EXEC before the response;
// dequeue and peek of a non-empty queue add FETCH for the registered read
// of the slot store. The response is on the rsp_ ports for exactly one cycle
// with rsp_valid high and cannot be held off, so capture it then. Writing the
// capacity register (only while busy is low) clamps it to 2..DEPTH and
// empties the queue.
module circular_queue_one_slot_open_top #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [cq_pkg::MODE_W-1:0]         req_mode,
   input  logic signed [cq_pkg::WORD_W-1:0]  req_value,
   output logic                              rsp_valid,
   output logic signed [cq_pkg::WORD_W-1:0]  rsp_data,
   output logic [cq_pkg::STATUS_W-1:0]       rsp_status,
   output logic                              rsp_full_flag,
   output logic                              rsp_empty_flag,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cq_pkg::CSR_W-1:0]          csr_capacity_in_use
);

   import cq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   cq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .csr_ready (csr_ready)
   );

   cq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_mode            (req_mode),
      .req_value           (req_value),
      .csr_write           (csr_valid && csr_ready),
      .csr_capacity_in_use (csr_capacity_in_use),
      .rsp_valid           (rsp_valid),
      .rsp_data            (rsp_data),
      .rsp_status          (rsp_status),
      .rsp_full_flag       (rsp_full_flag),
      .rsp_empty_flag      (rsp_empty_flag)
   );

endmodule
